// ===== hdl/dmpt_pkg.sv =====
package dmpt_pkg;

  localparam int EntriesDef = 512;
  localparam int PidBitsDef = 16;
  localparam int OffBits = 12;
  localparam int PageBits = 20;
  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_INVAL_PAGE = 3'd2,
    OP_INVAL_PID = 3'd3,
    OP_STATS = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [15:0] proc_id;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] perm_flags;
  } in_word_t;

  typedef struct packed {
    logic hit;
    logic [31:0] trans_addr;
    logic [11:0] hit_flags;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_word_t;

endpackage

// ===== hdl/direct_mapped_pid_tagged_tlb_unit.sv =====
// Direct-mapped translation cache tagged by process id and virtual page.
// Input channel: drive in_word and raise in_start; the word is taken at a
// rising edge with in_start high and in_busy low.
// Result channel: every op returns one word on out_word for exactly one
// cycle, marked by out_strobe; the receiver cannot stall.
// Ops: lookup, insert, invalidate page, invalidate pid, read statistics.
// Single-entry ops pass the front queue register, the registered read of
// S_READ and the output register; the back takes the next op only once it
// is back in idle, after the read-then-write of one memory entry. A pid
// flush sweeps all ENTRIES entries, one per cycle.
// A one-word queue lets the front accept the next op while the back works.
// ENTRIES must be a power of two; the index is the low bits of the hash.
// Reset clears the valid bits and the hit and miss counters; the tag and
// data memories are not cleared and need no clearing pass.
module direct_mapped_pid_tagged_tlb_unit #(
  parameter int ENTRIES = dmpt_pkg::EntriesDef,
  parameter int PID_BITS = dmpt_pkg::PidBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  input  dmpt_pkg::in_word_t in_word,
  output logic in_busy,
  output logic out_strobe,
  output dmpt_pkg::out_word_t out_word
);
  import dmpt_pkg::*;
  localparam int IdxBits = $clog2(ENTRIES);

  logic q_valid, q_pop;
  in_word_t q_word;
  logic [IdxBits-1:0] q_idx;

  dmpt_front #(.ENTRIES(ENTRIES), .PID_BITS(PID_BITS), .IDX_BITS(IdxBits)) u_front (
    .clk, .rst_n, .in_start, .in_word, .in_busy,
    .q_valid, .q_word, .q_idx, .q_pop
  );

  dmpt_back #(.ENTRIES(ENTRIES), .PID_BITS(PID_BITS), .IDX_BITS(IdxBits)) u_back (
    .clk, .rst_n, .q_valid, .q_word, .q_idx, .q_pop, .out_strobe, .out_word
  );
endmodule

// ===== hdl/dmpt_front.sv =====
module dmpt_front #(
  parameter int ENTRIES = dmpt_pkg::EntriesDef,
  parameter int PID_BITS = dmpt_pkg::PidBitsDef,
  parameter int IDX_BITS = $clog2(ENTRIES)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  input  dmpt_pkg::in_word_t in_word,
  output logic in_busy,
  output logic q_valid,
  output dmpt_pkg::in_word_t q_word,
  output logic [IDX_BITS-1:0] q_idx,
  input  logic q_pop
);
  import dmpt_pkg::*;

  // pid bits that take part in the hash
  localparam logic [15:0] PidMask = (PID_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << PID_BITS) - 32'd1);

  // one-entry queue between front and back
  logic q_valid_r, q_valid_nxt;
  in_word_t q_word_r;
  logic [IDX_BITS-1:0] q_idx_r, idx_c;
  logic [31:0] hash_c;
  logic take_c;

  // index hash on the page-aligned address
  assign hash_c = 32'(in_word.proc_id & PidMask) ^
                  32'({in_word.virt_addr[31:OffBits], {OffBits{1'b0}}} * HashMult);
  // ENTRIES is a power of two, so the modulo keeps the low hash bits
  assign idx_c = hash_c[IDX_BITS-1:0];

  assign in_busy = q_valid_r && !q_pop;
  assign take_c = in_start && !in_busy;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (q_pop) q_valid_nxt = 1'b0;
    if (take_c) q_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
    if (take_c) begin
      q_word_r <= in_word;
      q_idx_r <= idx_c;
    end
  end

  assign q_valid = q_valid_r;
  assign q_word = q_word_r;
  assign q_idx = q_idx_r;
endmodule

// ===== hdl/dmpt_back.sv =====
module dmpt_back #(
  parameter int ENTRIES = dmpt_pkg::EntriesDef,
  parameter int PID_BITS = dmpt_pkg::PidBitsDef,
  parameter int IDX_BITS = $clog2(ENTRIES)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  dmpt_pkg::in_word_t q_word,
  input  logic [IDX_BITS-1:0] q_idx,
  output logic q_pop,
  output logic out_strobe,
  output dmpt_pkg::out_word_t out_word
);
  import dmpt_pkg::*;

  localparam int TagW = PID_BITS + PageBits;
  localparam int DataW = PageBits + OffBits;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WALK} st_t;

  logic [TagW-1:0] tag_mem [ENTRIES];
  logic [DataW-1:0] data_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  st_t st_r;
  in_word_t w_r;
  logic [IDX_BITS-1:0] idx_r, rd_idx_c;
  logic [TagW-1:0] tag_rd_r;
  logic [DataW-1:0] data_rd_r;
  logic vld_rd_r, last_r;
  logic [31:0] hits_r, miss_r;
  logic out_strobe_r;
  out_word_t out_r;
  out_word_t res_c;
  logic [PID_BITS-1:0] pid_c;
  logic match_c, pid_match_c;

  assign pid_c = PID_BITS'(w_r.proc_id);
  assign match_c = vld_rd_r && tag_rd_r == {pid_c, w_r.virt_addr[31:OffBits]};
  assign pid_match_c = vld_rd_r && tag_rd_r[TagW-1:PageBits] == pid_c;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  // a pid flush starts its sweep at entry zero
  assign rd_idx_c = (st_r != S_IDLE) ? idx_r + 1'b1 :
                    (op_t'(q_word.op) == OP_INVAL_PID) ? '0 : q_idx;

  // registered memory read
  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[rd_idx_c];
    data_rd_r <= data_mem[rd_idx_c];
    vld_rd_r <= valid_r[rd_idx_c];
    if (st_r == S_READ && op_t'(w_r.op) == OP_INSERT) begin
      tag_mem[idx_r] <= {pid_c, w_r.virt_addr[31:OffBits]};
      data_mem[idx_r] <= {w_r.phys_addr[31:OffBits], w_r.perm_flags};
    end
  end

  // result word of a single-entry op
  always_comb begin
    res_c = '0;
    unique case (w_r.op)
      OP_LOOKUP: begin
        if (match_c) begin
          res_c.hit = 1'b1;
          res_c.trans_addr = {data_rd_r[DataW-1:OffBits], w_r.virt_addr[OffBits-1:0]};
          res_c.hit_flags = data_rd_r[OffBits-1:0];
        end
      end
      OP_STATS: begin
        res_c.hit_total = hits_r;
        res_c.miss_total = miss_r;
      end
      default: ;
    endcase
  end

  // sequencer: read entry, then act; pid flush sweeps every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      hits_r <= '0;
      miss_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            w_r <= q_word;
            if (op_t'(q_word.op) == OP_INVAL_PID) begin
              idx_r <= '0;
              last_r <= (ENTRIES == 1);
              st_r <= S_WALK;
            end else begin
              idx_r <= q_idx;
              st_r <= S_READ;
            end
          end
        end
        S_READ: begin
          out_r <= res_c;
          out_strobe_r <= 1'b1;
          st_r <= S_IDLE;
          unique case (w_r.op)
            OP_LOOKUP: begin
              if (match_c) begin
                hits_r <= hits_r + 32'd1;
              end else begin
                miss_r <= miss_r + 32'd1;
              end
            end
            OP_INSERT: valid_r[idx_r] <= 1'b1;
            OP_INVAL_PAGE: if (match_c) valid_r[idx_r] <= 1'b0;
            default: ;
          endcase
        end
        S_WALK: begin
          if (pid_match_c) valid_r[idx_r] <= 1'b0;
          idx_r <= idx_r + 1'b1;
          last_r <= (32'(idx_r) + 2 == ENTRIES);
          if (last_r) begin
            out_r <= '0;
            out_strobe_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word = out_r;
endmodule

// ===== hdl/dmpt_checker.sv =====
module dmpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_busy,
  input logic out_strobe,
  input dmpt_pkg::out_word_t out_word
);
  import dmpt_pkg::*;

  // no result straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
  // no two results come on consecutive cycles
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back-to-back strobes");
  // a hit carries a zero hit total
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.hit |-> out_word.hit_total == '0)
    else $error("hit with totals");
  // the block is not busy straight after reset
  a_busy: assert property (@(posedge clk) !rst_n |=> !in_busy)
    else $error("busy after reset");
endmodule

bind direct_mapped_pid_tagged_tlb_unit dmpt_checker u_chk (
  .clk, .rst_n, .in_busy, .out_strobe, .out_word
);
